// ----- rtl/ptg_pkg.sv -----
// Package for the plasma texel generator: sizes, command and register codes,
// the quarter-wave sine table and the table lookup functions.
// No dependencies.
package ptg_pkg;

  localparam int TEX_DIM        = 256;
  localparam int TEX_SHIFT      = $clog2(TEX_DIM);
  localparam int OSC_COUNT      = 9;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
  localparam int QSIZE          = 1 << QUARTER_BITS;
  localparam int RATE_BITS      = 18;
  localparam int NUM_STAGES     = 12;

  localparam logic [31:0] PI_HALF_Q30 = 32'd1686629713;
  localparam logic [21:0] ZOOM_STEP   = 22'd3435974;
  localparam logic [53:0] RATE_RESET  = 54'd7045628668252287;
  // ceil(2^35/10): exact floor(x/10) for any 32-bit x after >> 35
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  // floor(2^37/100): estimate of x/100, off by at most two
  localparam logic [30:0] RECIP100    = 31'd1374389534;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  typedef enum logic [1:0] {
    CMD_PIXEL     = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_SET_PHASE = 2'd2,
    CMD_UNUSED    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SATURATION = 3'd0,
    REG_ZOOM       = 3'd1,
    REG_RATES_LOW  = 3'd2,
    REG_RATES_MID  = 3'd3,
    REG_RATES_HIGH = 3'd4
  } reg_e;

  typedef logic signed [15:0] sine_tab_t [QSIZE+1];

  // Elaboration only: Taylor series in Q2.30, rounded to Q1.15.
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int k = 0; k <= QSIZE; k++) begin
      x    = (64'(PI_HALF_Q30) * 64'(k)) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = 64'sd0;
      for (int n = 1; n <= 15; n += 2) begin
        if (((n >> 1) & 1) == 0) begin
          sum = sum + $signed(term);
        end else begin
          sum = sum - $signed(term);
        end
        t = (term * x2) >> 30;
        case (n)
          1:       term = t / 64'd6;
          3:       term = t / 64'd20;
          5:       term = t / 64'd42;
          7:       term = t / 64'd72;
          9:       term = t / 64'd110;
          11:      term = t / 64'd156;
          13:      term = t / 64'd210;
          default: term = t / 64'd272;
        endcase
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      r = $signed((64'(sum) * 64'd32767 + 64'd536870912) >> 30);
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end
      tab[k] = 16'(r);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  function automatic logic signed [15:0] sine_q15(logic [31:0] a);
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    logic [QUARTER_BITS:0]     k;
    logic signed [15:0]        m;
    idx  = a[31 -: SINE_ADDR_BITS];
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    k    = {1'b0, idx[QUARTER_BITS-1:0]};
    if (quad[0]) begin
      k = (QUARTER_BITS+1)'(QSIZE) - k;
    end
    m = SINE_TAB[k];
    return quad[1] ? -m : m;
  endfunction

  function automatic logic signed [15:0] cosine_q15(logic [31:0] a);
    return sine_q15(a + QUARTER_TURN);
  endfunction

endpackage

// ----- rtl/plasma_texel_generator.sv -----
// Plasma texel generator: oscillator phase state and the pixel pipeline.
// Depends on ptg_pkg.
//
// Usage: input beats on in_valid_i/in_ready_o carry a command. A pixel beat
// (row_i, col_i) yields one result beat of red/green/blue/alpha on
// out_valid_o/out_ready_i. A frame-tick beat adds each oscillator rate to its
// phase; a set-phase beat loads one phase (index above 8 is dropped). Neither
// yields a result. Phases are sampled when a pixel beat is taken, so ticks may
// follow pixels at once.
// Throughput: one beat per cycle while the output is not stalled. A pixel beat
// passes through the twelve register stages, the first loaded at the accepting
// edge (lookups, coordinate multiply, four angle products, angle sums,
// sin/cos lookup, product, square, saturation multiply, reciprocal multiply,
// correction, grey, tint).
// Stall: the whole pipeline holds while the output beat waits, and in_ready_o
// drops with it; nothing is lost or repeated.
// Configuration beats on cfg_valid_i are always taken (cfg_ready_o high).
// Reset: phases clear to zero, saturation 100, zoom 50, all rates 102527;
// the pipeline empties.
module plasma_texel_generator
  import ptg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [53:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  col_i,
  input  logic [3:0]  osc_index_i,
  input  logic [31:0] phase_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o
);

  logic [6:0]  sat_q, zoom_q;
  logic [53:0] rates_q [3];
  logic [31:0] phase_q [OSC_COUNT];
  logic [NUM_STAGES-1:0] vld_q;

  logic adv, accept;
  logic [6:0] sat_c, zm_c;

  assign cfg_ready_o = 1'b1;
  assign adv         = !vld_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign accept      = in_valid_i && adv;
  assign out_valid_o = vld_q[NUM_STAGES-1];

  always_comb begin
    sat_c = (sat_q > 7'd100) ? 7'd100 : sat_q;
    if (zoom_q == 7'd0) begin
      zm_c = 7'd1;
    end else if (zoom_q > 7'd100) begin
      zm_c = 7'd100;
    end else begin
      zm_c = zoom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q  <= 7'd100;
      zoom_q <= 7'd50;
      for (int i = 0; i < 3; i++) begin
        rates_q[i] <= RATE_RESET;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SATURATION: sat_q      <= cfg_data_i[6:0];
        REG_ZOOM:       zoom_q     <= cfg_data_i[6:0];
        REG_RATES_LOW:  rates_q[0] <= cfg_data_i;
        REG_RATES_MID:  rates_q[1] <= cfg_data_i;
        REG_RATES_HIGH: rates_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < OSC_COUNT; i++) begin
        phase_q[i] <= '0;
      end
    end else if (accept) begin
      case (cmd_i)
        CMD_TICK: begin
          for (int i = 0; i < OSC_COUNT; i++) begin
            phase_q[i] <= phase_q[i] + 32'(rates_q[i/3][RATE_BITS*(i%3) +: RATE_BITS]);
          end
        end
        CMD_SET_PHASE: begin
          if (osc_index_i < 4'(OSC_COUNT)) begin
            phase_q[osc_index_i] <= phase_value_i;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NUM_STAGES-2:0], accept && (cmd_i == CMD_PIXEL)};
    end
  end

  // floor(17*r/10) for a remainder r below ten
  function automatic logic [3:0] frac17(logic [3:0] r);
    case (r)
      4'd0:    return 4'd0;
      4'd1:    return 4'd1;
      4'd2:    return 4'd3;
      4'd3:    return 4'd5;
      4'd4:    return 4'd6;
      4'd5:    return 4'd8;
      4'd6:    return 4'd10;
      4'd7:    return 4'd11;
      4'd8:    return 4'd13;
      default: return 4'd15;
    endcase
  endfunction

  // tint factors and saturation ride along in shift lines
  logic [15:0] f_q   [NUM_STAGES-1][3];
  logic [6:0]  sat_l [7];

  logic [14:0]        s1_rz, s1_cz;
  logic signed [15:0] s1_c [4];
  logic [31:0]        s1_ph2x2, s1_ph5;
  logic [63:0]        s1_m5;

  logic [31:0]        s2_ur, s2_uc, s2_w5, s2_ph2x2;
  logic signed [15:0] s2_c [4];
  logic [28:0]        q5;
  logic [3:0]         r5;

  logic [31:0] s3_s [4];
  logic [3:0]  s3_neg;
  logic [31:0] s3_ph2x2, s3_w5;
  logic [16:0] mag [4];

  logic [31:0] s4_a, s4_b;
  logic [31:0] sn [4];

  logic signed [15:0] s5_sa, s5_cb;
  logic signed [31:0] prod;
  logic signed [32:0] bias;
  logic [30:0]        s6_p, s7_p2, s10_p3;
  logic [36:0]        s8_t, s9_t, rem;
  logic [62:0]        s9_m;
  logic [30:0]        q_est, p3_c;
  logic [7:0]         s11_g;

  always_comb begin
    q5 = s1_m5[63:35];
    r5 = 4'(s1_ph5 - 32'(q5) * 32'd10);
    for (int i = 0; i < 4; i++) begin
      mag[i] = s2_c[i][15] ? 17'(-$signed({s2_c[i][15], s2_c[i]}))
                           : {1'b0, s2_c[i]};
    end
    for (int i = 0; i < 4; i++) begin
      sn[i] = s3_neg[i] ? 32'd0 - s3_s[i] : s3_s[i];
    end
    prod  = s5_sa * s5_cb;
    bias  = 33'(prod) + 33'sd1073741824;
    q_est = s9_m[62:32];
    rem   = s9_t - 37'(q_est) * 37'd100;
    if (rem >= 37'd200) begin
      p3_c = q_est + 31'd2;
    end else if (rem >= 37'd100) begin
      p3_c = q_est + 31'd1;
    end else begin
      p3_c = q_est;
    end
    if (p3_c > 31'h4000_0000) begin
      p3_c = 31'h4000_0000;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // stage 1: sample phases, cosine lookups, row and column times zoom
      for (int j = 0; j < 3; j++) begin
        f_q[0][j] <= 16'(17'sd32768 + 17'(cosine_q15(phase_q[6+j])));
      end
      for (int s = 1; s < NUM_STAGES-1; s++) begin
        f_q[s] <= f_q[s-1];
      end
      sat_l[0] <= sat_c;
      for (int s = 1; s < 7; s++) begin
        sat_l[s] <= sat_l[s-1];
      end
      s1_rz    <= 15'(row_i) * 15'(zm_c);
      s1_cz    <= 15'(col_i) * 15'(zm_c);
      s1_c[0]  <= cosine_q15(phase_q[0]);
      s1_c[1]  <= cosine_q15(phase_q[1]);
      s1_c[2]  <= cosine_q15(phase_q[3]);
      s1_c[3]  <= cosine_q15(phase_q[4]);
      s1_ph2x2 <= {phase_q[2][30:0], 1'b0};
      s1_ph5   <= phase_q[5];
      s1_m5    <= 64'(phase_q[5]) * 64'(RECIP10);
      // stage 2: coordinates in turns, 1.7 times phase five
      s2_ur    <= 32'((37'(s1_rz) * 37'(ZOOM_STEP)) >> TEX_SHIFT);
      s2_uc    <= 32'((37'(s1_cz) * 37'(ZOOM_STEP)) >> TEX_SHIFT);
      s2_w5    <= 32'(q5) * 32'd17 + 32'(frac17(r5));
      s2_c     <= s1_c;
      s2_ph2x2 <= s1_ph2x2;
      // stage 3: products, truncated toward zero
      s3_s[0]  <= 32'((49'(s2_ur) * 49'(mag[0])) >> 15);
      s3_s[1]  <= 32'((49'(s2_uc) * 49'(mag[1])) >> 15);
      s3_s[2]  <= 32'((49'(s2_ur) * 49'(mag[2])) >> 15);
      s3_s[3]  <= 32'((49'(s2_uc) * 49'(mag[3])) >> 15);
      for (int i = 0; i < 4; i++) begin
        s3_neg[i] <= s2_c[i][15];
      end
      s3_ph2x2 <= s2_ph2x2;
      s3_w5    <= s2_w5;
      // stage 4: angle sums
      s4_a <= sn[0] + sn[1] + s3_ph2x2;
      s4_b <= sn[2] - sn[3] + s3_w5;
      // stage 5
      s5_sa <= sine_q15(s4_a);
      s5_cb <= cosine_q15(s4_b);
      // stage 6: p = (s*c + 2^30) / 2
      s6_p  <= bias[31:1];
      // stage 7
      s7_p2 <= 31'((62'(s6_p) * 62'(s6_p)) >> 30);
      // stage 8
      s8_t  <= 37'(s7_p2) * 37'(sat_l[6]);
      // stage 9: reciprocal estimate of t/100
      s9_m  <= 63'(s8_t[36:5]) * 63'(RECIP100);
      s9_t  <= s8_t;
      // stage 10: correct the estimate
      s10_p3 <= p3_c;
      // stage 11
      s11_g <= 8'((39'(s10_p3) * 39'd255) >> 30);
      // stage 12: tints and alpha
      red_o   <= 8'((24'(s11_g) * 24'(f_q[NUM_STAGES-2][0])) >> 16);
      green_o <= 8'((24'(s11_g) * 24'(f_q[NUM_STAGES-2][1])) >> 16);
      blue_o  <= 8'((24'(s11_g) * 24'(f_q[NUM_STAGES-2][2])) >> 16);
      alpha_o <= 8'((24'(s11_g) * 24'd29493) >> 15);
    end
  end

endmodule

// ----- rtl/ptg_checker.sv -----
// Port-level checks for the plasma texel generator, bound to the top level.
// Depends on plasma_texel_generator's port list.
module ptg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_ready_o,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic [7:0]  alpha_o
);

  // a stalled result beat stays valid, with red and alpha held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(alpha_o))
    else $error("stalled result beat changed");

  // input side only backs up behind a stalled output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // tints never exceed grey and alpha is nine tenths of grey rounded down, so no tint is more than 26 above alpha
  a_tint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (9'(red_o) <= 9'(alpha_o) + 9'd26) &&
                    (9'(green_o) <= 9'(alpha_o) + 9'd26) &&
                    (9'(blue_o) <= 9'(alpha_o) + 9'd26))
    else $error("tint above grey");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port refused a beat");

endmodule

bind plasma_texel_generator ptg_checker u_ptg_checker (.*);
